// ----- design/sign_magnitude_accumulator_alu_assert.svh -----
// Assertion macros for the sign-magnitude accumulator ALU.
`ifndef SIGN_MAGNITUDE_ACCUMULATOR_ALU_ASSERT_SVH
`define SIGN_MAGNITUDE_ACCUMULATOR_ALU_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define SMACC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sign_magnitude_accumulator_alu: assertion failed");

// Check a consequent in the cycle after its antecedent.
`define SMACC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sign_magnitude_accumulator_alu: assertion failed");

`endif

// ----- design/smacc_pkg.sv -----
// Shared types and constants of the sign-magnitude accumulator ALU.
package smacc_pkg;

  localparam int unsigned WordW   = 15;
  localparam int unsigned MagW    = 14;
  localparam int unsigned OpW     = 7;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CntW    = $clog2(MagW + 1);

  typedef logic [WordW-1:0]   word_t;
  typedef logic [MagW-1:0]    mag_t;
  typedef logic [OpW-1:0]     op_t;
  typedef logic [StatusW-1:0] status_t;
  typedef logic [CntW-1:0]    cnt_t;

  localparam op_t OpAdd = 7'h30;
  localparam op_t OpSub = 7'h31;
  localparam op_t OpDiv = 7'h32;
  localparam op_t OpMul = 7'h33;
  localparam op_t OpRot = 7'h62;

  localparam status_t StOk   = 2'd0;
  localparam status_t StIll  = 2'd1;
  localparam status_t StDiv0 = 2'd2;

  localparam cnt_t CntLast = CntW'(MagW);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StRun  = 2'b10
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic is_div;
  } unit_ctl_t;

  typedef struct packed {
    logic [MagW:0] sum;
    mag_t          diff;
    logic          a_lt_b;
  } addsub_res_t;

endpackage

// ----- design/smacc_if.sv -----
// Valid/ready channel interfaces for requests and responses.
interface smacc_req_if;
  logic               valid;
  logic               ready;
  smacc_pkg::op_t     req_type;
  smacc_pkg::word_t   mem_word;

  modport source (output valid, output req_type, output mem_word, input ready);
  modport sink (input valid, input req_type, input mem_word, output ready);
endinterface

interface smacc_rsp_if;
  logic                valid;
  logic                ready;
  smacc_pkg::word_t    acc_out;
  smacc_pkg::status_t  status;

  modport source (output valid, output acc_out, output status, input ready);
  modport sink (input valid, input acc_out, input status, output ready);
endinterface

// ----- design/sign_magnitude_accumulator_alu.sv -----
// Sign-magnitude accumulator ALU top level with sequencer and accumulator.
// Each request runs 14 serial steps of the 14-bit serial add, multiply and divide units
// and then a writeback; a new request is taken only after the previous one writes back.
// A stalled response holds the writeback.
// Reset: asynchronous, active low; clears the accumulator, the sequencer and response valid.
module sign_magnitude_accumulator_alu (
  input  logic         clk_i,
  input  logic         rst_ni,
  smacc_req_if.sink    req_i,
  smacc_rsp_if.source  rsp_o
);

  `include "sign_magnitude_accumulator_alu_assert.svh"

  smacc_pkg::state_e      state_q, state_d;
  smacc_pkg::cnt_t        cnt_q;
  smacc_pkg::word_t       acc_q, acc_d, w_q, out_acc_q;
  smacc_pkg::op_t         op_q;
  smacc_pkg::status_t     status_d, out_status_q;
  logic                   out_valid_q;
  smacc_pkg::unit_ctl_t   ctl;
  smacc_pkg::addsub_res_t as_res;
  smacc_pkg::word_t       md_mag, mag;
  logic                   accept, finish, sgn, nz, sv_eff;
  smacc_pkg::mag_t        ma, mv;

  assign req_i.ready = (state_q == smacc_pkg::StIdle);
  assign accept      = req_i.valid && req_i.ready;
  assign finish      = (state_q == smacc_pkg::StRun) && (cnt_q == smacc_pkg::CntLast)
                       && (!out_valid_q || rsp_o.ready);

  assign ctl.load   = accept;
  assign ctl.step   = (state_q == smacc_pkg::StRun) && (cnt_q != smacc_pkg::CntLast);
  assign ctl.is_div = (req_i.req_type == smacc_pkg::OpDiv);

  smacc_addsub u_addsub (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .ma_i   (acc_q[smacc_pkg::MagW-1:0]),
    .mv_i   (req_i.mem_word[smacc_pkg::MagW-1:0]),
    .res_o  (as_res)
  );

  smacc_muldiv u_muldiv (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .ma_i  (acc_q[smacc_pkg::MagW-1:0]),
    .mv_i  (req_i.mem_word[smacc_pkg::MagW-1:0]),
    .mag_o (md_mag)
  );

  assign ma     = acc_q[smacc_pkg::MagW-1:0];
  assign mv     = w_q[smacc_pkg::MagW-1:0];
  assign sv_eff = w_q[smacc_pkg::MagW] ^ (op_q == smacc_pkg::OpSub);

  always_comb begin
    status_d = smacc_pkg::StOk;
    acc_d    = acc_q;
    mag      = '0;
    sgn      = 1'b0;
    nz       = 1'b0;
    unique case (op_q) inside
      smacc_pkg::OpAdd, smacc_pkg::OpSub: begin
        if (acc_q[smacc_pkg::MagW] == sv_eff) begin
          mag = as_res.sum;
          sgn = sv_eff;
        end else begin
          mag = {1'b0, as_res.diff};
          sgn = as_res.a_lt_b ? sv_eff : acc_q[smacc_pkg::MagW];
        end
        nz    = (mag != '0);
        acc_d = {mag[smacc_pkg::MagW] | (sgn & nz), mag[smacc_pkg::MagW-1:0]};
      end
      smacc_pkg::OpMul: begin
        mag   = md_mag;
        sgn   = acc_q[smacc_pkg::MagW] ^ w_q[smacc_pkg::MagW];
        nz    = (ma != '0) && (mv != '0);
        acc_d = {mag[smacc_pkg::MagW] | (sgn & nz), mag[smacc_pkg::MagW-1:0]};
      end
      smacc_pkg::OpDiv: begin
        if (mv == '0) begin
          status_d = smacc_pkg::StDiv0;
        end else begin
          mag   = md_mag;
          sgn   = acc_q[smacc_pkg::MagW] ^ w_q[smacc_pkg::MagW];
          nz    = (mag != '0);
          acc_d = {mag[smacc_pkg::MagW] | (sgn & nz), mag[smacc_pkg::MagW-1:0]};
        end
      end
      smacc_pkg::OpRot: begin
        acc_d = {w_q[smacc_pkg::MagW-1:0], w_q[smacc_pkg::MagW]};
      end
      default: begin
        status_d = smacc_pkg::StIll;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      smacc_pkg::StIdle: if (accept) state_d = smacc_pkg::StRun;
      smacc_pkg::StRun:  if (finish) state_d = smacc_pkg::StIdle;
      default:           state_d = smacc_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= smacc_pkg::StIdle;
      cnt_q       <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cnt_q <= '0;
      end else if (ctl.step) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (finish) begin
        acc_q       <= acc_d;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= req_i.req_type;
      w_q  <= req_i.mem_word;
    end
    if (finish) begin
      out_acc_q    <= acc_d;
      out_status_q <= status_d;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.acc_out = out_acc_q;
  assign rsp_o.status  = out_status_q;

  `SMACC_ASSERT_SAME(a_busy_not_ready, state_q == smacc_pkg::StRun, !req_i.ready)
  `SMACC_ASSERT_NEXT(a_err_keeps_acc, finish && status_d != smacc_pkg::StOk, acc_q == $past(acc_q))
  `SMACC_ASSERT_NEXT(a_finish_shows_acc, finish, rsp_o.valid && rsp_o.acc_out == acc_q)

endmodule

// ----- design/smacc_addsub.sv -----
// Bit-serial magnitude adder and dual subtractor, LSB first.
module smacc_addsub (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  smacc_pkg::unit_ctl_t    ctl_i,
  input  smacc_pkg::mag_t         ma_i,
  input  smacc_pkg::mag_t         mv_i,
  output smacc_pkg::addsub_res_t  res_o
);

  smacc_pkg::mag_t a_sr_q, b_sr_q, sum_sr_q, dab_sr_q, dba_sr_q;
  logic            c_q, bab_q, bba_q;
  logic            a_bit, b_bit, x_bit;

  assign a_bit = a_sr_q[0];
  assign b_bit = b_sr_q[0];
  assign x_bit = a_bit ^ b_bit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q   <= 1'b0;
      bab_q <= 1'b0;
      bba_q <= 1'b0;
    end else if (ctl_i.load) begin
      c_q   <= 1'b0;
      bab_q <= 1'b0;
      bba_q <= 1'b0;
    end else if (ctl_i.step) begin
      c_q   <= (a_bit & b_bit) | (x_bit & c_q);
      bab_q <= (~a_bit & b_bit) | (~x_bit & bab_q);
      bba_q <= (~b_bit & a_bit) | (~x_bit & bba_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      a_sr_q <= ma_i;
      b_sr_q <= mv_i;
    end else if (ctl_i.step) begin
      a_sr_q   <= a_sr_q >> 1;
      b_sr_q   <= b_sr_q >> 1;
      sum_sr_q <= {x_bit ^ c_q, sum_sr_q[smacc_pkg::MagW-1:1]};
      dab_sr_q <= {x_bit ^ bab_q, dab_sr_q[smacc_pkg::MagW-1:1]};
      dba_sr_q <= {x_bit ^ bba_q, dba_sr_q[smacc_pkg::MagW-1:1]};
    end
  end

  assign res_o.sum    = {c_q, sum_sr_q};
  assign res_o.a_lt_b = bab_q;
  assign res_o.diff   = bab_q ? dba_sr_q : dab_sr_q;

endmodule

// ----- design/smacc_muldiv.sv -----
// Shift-add multiplier and restoring divider, one multiplier or quotient bit per cycle while stepping.
module smacc_muldiv (
  input  logic                  clk_i,
  input  smacc_pkg::unit_ctl_t  ctl_i,
  input  smacc_pkg::mag_t       ma_i,
  input  smacc_pkg::mag_t       mv_i,
  output smacc_pkg::word_t      mag_o
);

  smacc_pkg::word_t r_q, s_q;
  smacc_pkg::mag_t  m_q, d_q;
  logic             div_q;
  smacc_pkg::word_t trial, dvs;
  logic             ge;

  assign dvs   = {1'b0, d_q};
  assign trial = {r_q[smacc_pkg::MagW-1:0], m_q[smacc_pkg::MagW-1]};
  assign ge    = trial >= dvs;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      r_q   <= '0;
      s_q   <= {1'b0, ma_i};
      m_q   <= ctl_i.is_div ? ma_i : mv_i;
      d_q   <= mv_i;
      div_q <= ctl_i.is_div;
    end else if (ctl_i.step) begin
      if (div_q) begin
        r_q <= ge ? trial - dvs : trial;
        m_q <= {m_q[smacc_pkg::MagW-2:0], ge};
      end else begin
        r_q <= r_q + (m_q[0] ? s_q : '0);
        s_q <= s_q << 1;
        m_q <= m_q >> 1;
      end
    end
  end

  assign mag_o = div_q ? {1'b0, m_q} : r_q;

endmodule

// ----- verif/tb.sv -----
// Testbench for the sign-magnitude accumulator ALU: directed and random transactions, scoreboard.
import smacc_pkg::*;

class acc_scoreboard;
  typedef struct packed {
    word_t   acc;
    status_t st;
  } acc_rsp_t;

  acc_rsp_t    expected_rsp_q[$];
  word_t       acc;
  int unsigned errors;

  function new();
    acc    = '0;
    errors = 0;
  endfunction

  function int sm_to_int(word_t w);
    int mag;
    mag = int'(w[MagW-1:0]);
    return w[WordW-1] ? -mag : mag;
  endfunction

  function word_t int_to_sm(int r);
    logic [31:0] bits;
    if (r < 0) begin
      bits = 32'(-r) | 32'h4000;
    end else begin
      bits = 32'(r);
    end
    return bits[WordW-1:0];
  endfunction

  function void note_request(op_t op, word_t w);
    int       a;
    int       v;
    acc_rsp_t rsp;
    a      = sm_to_int(acc);
    v      = sm_to_int(w);
    rsp.st = StOk;
    case (op)
      OpAdd: acc = int_to_sm(a + v);
      OpSub: acc = int_to_sm(a - v);
      OpMul: acc = int_to_sm(a * v);
      OpDiv: begin
        if (w[MagW-1:0] == '0) begin
          rsp.st = StDiv0;
        end else begin
          acc = int_to_sm(a / v);
        end
      end
      OpRot: acc = {w[WordW-2:0], w[WordW-1]};
      default: rsp.st = StIll;
    endcase
    rsp.acc = acc;
    expected_rsp_q.push_back(rsp);
  endfunction

  function void check_response(word_t acc_o, status_t st_o);
    acc_rsp_t exp_rsp;
    if (expected_rsp_q.size() == 0) begin
      if (errors < 10) begin
        $display("unexpected response: acc %h status %0d", acc_o, st_o);
      end
      errors++;
    end else begin
      exp_rsp = expected_rsp_q.pop_front();
      if (exp_rsp.acc !== acc_o || exp_rsp.st !== st_o) begin
        if (errors < 10) begin
          $display("mismatch: expected acc %h status %0d, got acc %h status %0d",
                   exp_rsp.acc, exp_rsp.st, acc_o, st_o);
        end
        errors++;
      end
    end
  endfunction

  function int unsigned pending();
    return expected_rsp_q.size();
  endfunction
endclass

module tb;
  logic clk;
  logic rst_n;
  bit   idle_en;

  acc_scoreboard sb;

  smacc_req_if req_if ();
  smacc_rsp_if rsp_if ();

  sign_magnitude_accumulator_alu u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  initial clk = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_en || r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic op_t pick_op();
    case ($urandom_range(0, 9))
      0, 1:    return op_t'($urandom);
      2, 3:    return OpAdd;
      4:       return OpSub;
      5, 6:    return OpDiv;
      7:       return OpMul;
      default: return OpRot;
    endcase
  endfunction

  function automatic word_t pick_word();
    case ($urandom_range(0, 9))
      0:       return 15'h0000;
      1:       return 15'h4000;
      2:       return 15'h3FFF;
      3:       return 15'h7FFF;
      4, 5:    return {1'($urandom), MagW'($urandom_range(1, 15))};
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic send(op_t op, word_t w);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= op;
    req_if.mem_word <= w;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(op, w);
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned hold;
    hold = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_if.valid && rsp_if.ready) begin
        sb.check_response(rsp_if.acc_out, rsp_if.status);
      end
      if (hold > 0) begin
        rsp_if.ready <= 1'b0;
        hold--;
      end else begin
        rsp_if.ready <= 1'b1;
        if ($urandom_range(0, 5) == 0) begin
          hold = pick_gap();
        end
      end
    end
  end

  initial begin
    #(20 * 400000);
    $display("FAIL");
    $finish;
  end

  initial begin
    sb = new();
    idle_en = 1'b1;
    rst_n <= 1'b0;
    req_if.valid    <= 1'b0;
    req_if.req_type <= '0;
    req_if.mem_word <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(OpAdd, 15'h3FFF);
    send(OpAdd, 15'h3FFF);
    send(OpRot, 15'h0005);
    send(OpDiv, 15'h0000);
    send(OpDiv, 15'h4000);
    send(OpDiv, 15'h4003);
    send(OpDiv, 15'h0002);
    send(OpMul, 15'h7FFF);
    send(OpMul, 15'h3FFF);
    send(7'h00, 15'h7FFF);
    send(7'h7F, 15'h0000);
    send(OpRot, 15'h2000);
    send(OpAdd, 15'h0000);
    send(OpRot, 15'h2000);
    send(OpSub, 15'h4000);
    send(OpRot, 15'h7FFF);
    send(OpSub, 15'h3FFF);
    send(OpRot, 15'h4000);
    send(OpSub, 15'h7FFF);
    send(OpMul, 15'h0000);
    send(OpRot, 15'h1234);
    send(7'h2F, 15'h1555);
    send(7'h34, 15'h2AAA);
    send(7'h61, 15'h0001);
    send(7'h63, 15'h7FFE);
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      idle_en = (phase != 1);
      for (int i = 0; i < 150; i++) begin
        send(pick_op(), pick_word());
      end
      drain_results();
    end

    repeat (64) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
